>>> rtl/ptf_pkg.sv
// ----------------------------------------------------------------------------
// ptf_pkg: process trace filter shared types and constants
// Command and status codes, controller states and the records passed
// between the controller and the row of exception cells.
// ----------------------------------------------------------------------------
package ptf_pkg;

    typedef enum logic [1:0] {
        CMD_EVENT   = 2'd0,
        CMD_ENABLE  = 2'd1,
        CMD_DISABLE = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_FULL = 2'd1,
        ST_SKIP = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_SCAN   = 2'd1,
        S_FINISH = 2'd2
    } t_state;

    // Scan token flags handed from cell to cell
    typedef struct packed {
        logic match_done;   // some earlier cell held the id
        logic found;        // that cell was live
        logic free_done;    // some earlier cell was deleted or empty
    } t_scan;

    // Table update broadcast to every cell
    typedef struct packed {
        logic clear;        // empty the whole table
        logic add;          // write the id into the first free cell
        logic remove;       // mark the matching cell deleted
    } t_upd;

    localparam logic [5:0]  TERM_ZOMBIE    = 6'h20;
    localparam logic [5:0]  TERM_DEAD      = 6'h10;
    localparam logic [15:0] RUN_RUNNING    = 16'h0000;
    localparam logic [15:0] RUN_INTERRUPT  = 16'h0001;
    localparam logic [15:0] RUN_UNINTR     = 16'h0002;
    localparam logic [15:0] RUN_STOPPED    = 16'h0004;
    localparam logic [15:0] RUN_STOP_WKILL = 16'h0104;

endpackage

>>> rtl/ptf_cell.sv
// ----------------------------------------------------------------------------
// ptf_cell: one exception table entry
// Holds an id and its delete mark, checks a passing scan token against
// them and remembers whether it was the first match or the first free slot.
// ----------------------------------------------------------------------------
module ptf_cell #(
    parameter int ID_BITS = 22
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_tok_v,
    input  ptf_pkg::t_scan      i_scan,
    input  logic [ID_BITS-1:0]  i_req_id,
    input  ptf_pkg::t_upd       i_upd,
    output logic                o_tok_v,
    output ptf_pkg::t_scan      o_scan
);
    import ptf_pkg::*;

    logic [ID_BITS-1:0] r_id,  n_id;
    logic               r_del, n_del;
    logic               r_hit, n_hit;
    logic               r_vac, n_vac;
    logic               r_tok_v;
    t_scan              r_scan, n_scan;
    logic               cell_match;
    logic               cell_free;

    assign cell_match = (r_id == i_req_id) && (i_req_id != '0);
    assign cell_free  = r_del || (r_id == '0);

    always_comb begin
        n_scan.match_done = i_scan.match_done | cell_match;
        n_scan.found      = i_scan.match_done ? i_scan.found : (cell_match & ~r_del);
        n_scan.free_done  = i_scan.free_done | cell_free;

        n_hit = r_hit;
        n_vac = r_vac;
        if (i_tok_v) begin
            n_hit = ~i_scan.match_done & cell_match & ~r_del;
            n_vac = ~i_scan.free_done & cell_free;
        end

        n_id  = r_id;
        n_del = r_del;
        if (i_upd.clear) begin
            n_id  = '0;
            n_del = 1'b0;
        end else if (i_upd.add && r_vac) begin
            n_id  = i_req_id;
            n_del = 1'b0;
        end else if (i_upd.remove && r_hit) begin
            n_del = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id    <= '0;
            r_del   <= 1'b0;
            r_hit   <= 1'b0;
            r_vac   <= 1'b0;
            r_tok_v <= 1'b0;
        end else begin
            r_id    <= n_id;
            r_del   <= n_del;
            r_hit   <= n_hit;
            r_vac   <= n_vac;
            r_tok_v <= i_tok_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan <= n_scan;
    end

    assign o_tok_v = r_tok_v;
    assign o_scan  = r_scan;

endmodule

>>> rtl/process_trace_filter_top.sv
// ----------------------------------------------------------------------------
// process_trace_filter_top: process state-change trace filter
// A row of ENTRIES exception cells scanned by a token, plus a controller
// that applies enable/disable commands and records events in a ring.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  request   in         i_valid / o_ready  i_cmd i_bulk i_proc_id i_is_leader
//                                          i_run_state i_term_state
//  result    out        o_valid / i_ready  o_status o_recorded o_slot
//                                          o_rec_proc_id o_rec_state
//                                          o_live_count o_mode_all o_fill_level
//
//  One request is in flight at a time; the token walks one cell per cycle,
//  and the next request is accepted once it has left the last cell.
//  A finished result waits in the output register; a new request may be
//  accepted meanwhile, and its update holds until that register is free.
//  Synchronous active-low reset empties the table and clears all counters.
module process_trace_filter_top #(
    parameter int ENTRIES = 16,
    parameter int ID_BITS = 22,
    localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int CNT_W  = $clog2(ENTRIES + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_cmd,
    input  logic               i_bulk,
    input  logic [ID_BITS-1:0] i_proc_id,
    input  logic               i_is_leader,
    input  logic [15:0]        i_run_state,
    input  logic [5:0]         i_term_state,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_status,
    output logic               o_recorded,
    output logic [SLOT_W-1:0]  o_slot,
    output logic [ID_BITS-1:0] o_rec_proc_id,
    output logic [15:0]        o_rec_state,
    output logic [CNT_W-1:0]   o_live_count,
    output logic               o_mode_all,
    output logic [CNT_W-1:0]   o_fill_level
);
    import ptf_pkg::*;

    localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(ENTRIES);
    localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(ENTRIES - 1);

    t_state r_state, n_state;

    // held request
    logic [1:0]         r_cmd;
    logic               r_bulk;
    logic [ID_BITS-1:0] r_req_id;
    logic               r_leader;
    logic [15:0]        r_rs;
    logic [5:0]         r_es;
    logic               r_inject;
    logic               r_found;
    logic               r_free;

    // architectural state
    logic [CNT_W-1:0]   r_live, n_live;
    logic               r_trace_all, n_trace_all;
    logic               r_started, n_started;
    logic [SLOT_W-1:0]  r_wslot, n_wslot;
    logic [CNT_W-1:0]   r_fill, n_fill;

    // output register
    logic               r_out_valid;
    logic [1:0]         r_status, n_status;
    logic               r_rec, n_rec;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic [ID_BITS-1:0] r_rid, n_rid;
    logic [15:0]        r_rstate, n_rstate;

    logic   accept;
    logic   finish_go;
    logic   tok_v  [ENTRIES+1];
    t_scan  scan   [ENTRIES+1];
    t_upd   upd_calc;
    t_upd   upd;
    logic   en;
    logic   traced;

    // ---------------- cell row ----------------
    assign tok_v[0] = r_inject;
    assign scan[0]  = '0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        ptf_cell #(.ID_BITS(ID_BITS)) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_tok_v  (tok_v[g]),
            .i_scan   (scan[g]),
            .i_req_id (r_req_id),
            .i_upd    (upd),
            .o_tok_v  (tok_v[g+1]),
            .o_scan   (scan[g+1])
        );
    end

    // ---------------- state machine ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_valid) n_state = S_SCAN;
            S_SCAN:   if (tok_v[ENTRIES]) n_state = S_FINISH;
            S_FINISH: if (!r_out_valid || i_ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready   = 1'b0;
        finish_go = 1'b0;
        case (r_state)
            S_IDLE:   o_ready   = 1'b1;
            S_SCAN:   finish_go = 1'b0;
            S_FINISH: finish_go = !r_out_valid || i_ready;
            default:  o_ready   = 1'b0;
        endcase
    end

    assign accept = i_valid && o_ready;

    // ---------------- command / event decision ----------------
    assign en = (r_cmd == CMD_ENABLE);

    always_comb begin
        if ((r_es == TERM_ZOMBIE) || (r_es == TERM_DEAD)) begin
            traced = 1'b1;
        end else begin
            traced = (r_rs == RUN_RUNNING) || (r_rs == RUN_INTERRUPT) ||
                     (r_rs == RUN_UNINTR) || (r_rs == RUN_STOPPED) ||
                     (r_rs == RUN_STOP_WKILL);
        end
    end

    always_comb begin
        upd_calc    = '0;
        n_live      = r_live;
        n_trace_all = r_trace_all;
        n_started   = r_started;
        n_wslot     = r_wslot;
        n_fill      = r_fill;
        n_status    = ST_DONE;
        n_rec       = 1'b0;
        n_slot      = '0;
        n_rid       = '0;
        n_rstate    = '0;
        case (r_cmd)
            CMD_ENABLE, CMD_DISABLE: begin
                n_started = 1'b1;
                if (r_bulk) begin
                    upd_calc.clear = 1'b1;
                    n_live         = '0;
                    n_trace_all    = en;
                end else if (r_req_id != '0) begin
                    if (r_trace_all != en) begin
                        if (!r_found) begin
                            if (!r_free) begin
                                n_status = ST_FULL;
                            end else begin
                                upd_calc.add = 1'b1;
                                if (r_live < CNT_MAX) n_live = r_live + 1'b1;
                            end
                        end
                    end else if (r_found) begin
                        upd_calc.remove = 1'b1;
                        if (r_live != '0) n_live = r_live - 1'b1;
                    end
                end
            end
            CMD_EVENT: begin
                n_status = ST_SKIP;
                if (r_started && r_leader && (r_trace_all != r_found) && traced) begin
                    n_status = ST_DONE;
                    n_rec    = 1'b1;
                    n_slot   = r_wslot;
                    n_rid    = r_req_id;
                    n_rstate = ((r_es == TERM_ZOMBIE) || (r_es == TERM_DEAD)) ?
                               {10'd0, r_es} : r_rs;
                    n_wslot  = (r_wslot == SLOT_MAX) ? '0 : r_wslot + 1'b1;
                    if (r_fill < CNT_MAX) n_fill = r_fill + 1'b1;
                end
            end
            default: n_status = ST_DONE;   // unused command: no effect
        endcase
    end

    assign upd = finish_go ? upd_calc : '0;

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_inject    <= 1'b0;
            r_live      <= '0;
            r_trace_all <= 1'b0;
            r_started   <= 1'b0;
            r_wslot     <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_inject <= accept;
            if (finish_go) begin
                r_live      <= n_live;
                r_trace_all <= n_trace_all;
                r_started   <= n_started;
                r_wslot     <= n_wslot;
                r_fill      <= n_fill;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd    <= i_cmd;
            r_bulk   <= i_bulk;
            r_req_id <= i_proc_id;
            r_leader <= i_is_leader;
            r_rs     <= i_run_state;
            r_es     <= i_term_state;
        end
        // capture the token leaving the last cell
        if (r_state == S_SCAN && tok_v[ENTRIES]) begin
            r_found <= scan[ENTRIES].found;
            r_free  <= scan[ENTRIES].free_done;
        end
        if (finish_go) begin
            r_status <= n_status;
            r_rec    <= n_rec;
            r_slot   <= n_slot;
            r_rid    <= n_rid;
            r_rstate <= n_rstate;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_recorded    = r_rec;
    assign o_slot        = r_slot;
    assign o_rec_proc_id = r_rid;
    assign o_rec_state   = r_rstate;
    assign o_live_count  = r_live;
    assign o_mode_all    = r_trace_all;
    assign o_fill_level  = r_fill;

endmodule

>>> rtl/ptf_checker.sv
// ----------------------------------------------------------------------------
// ptf_checker: port-level checks for the process trace filter
// Watches the top level ports only; attached by the bind below.
// ----------------------------------------------------------------------------
module ptf_checker #(
    parameter int ENTRIES = 16,
    parameter int ID_BITS = 22,
    localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int CNT_W  = $clog2(ENTRIES + 1)
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_ready,
    input logic [1:0]         o_status,
    input logic               o_recorded,
    input logic [SLOT_W-1:0]  o_slot,
    input logic [ID_BITS-1:0] o_rec_proc_id,
    input logic [15:0]        o_rec_state,
    input logic [CNT_W-1:0]   o_live_count,
    input logic [CNT_W-1:0]   o_fill_level
);
    import ptf_pkg::*;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(ENTRIES);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_rec_proc_id))
        else $error("result changed while stalled");

    // a recorded event always reports done
    a_rec_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_recorded |-> o_status == ST_DONE)
        else $error("recorded event with nonzero status");

    // unrecorded results carry empty record fields
    a_rec_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_recorded |-> o_slot == '0 && o_rec_proc_id == '0 && o_rec_state == '0)
        else $error("record fields set without a record");

    // counters never pass the table size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_live_count <= CNT_MAX && o_fill_level <= CNT_MAX)
        else $error("counter beyond capacity");

endmodule

bind process_trace_filter_top ptf_checker #(
    .ENTRIES (ENTRIES),
    .ID_BITS (ID_BITS)
) u_ptf_checker (.*);

>>> test/process_trace_filter_top_test.sv
// ----------------------------------------------------------------------------
// process_trace_filter_top_test: self-checking bench for the trace filter
// Streams enable/disable commands and state-change events through the
// request channel and compares every result against an in-bench model of
// the exception table, the trace mode and the record ring. Runs a directed
// opening, then random epochs under several idle and stall mixes, and a
// long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module process_trace_filter_top_test;
    import ptf_pkg::*;

    localparam int ENTRIES      = 16;
    localparam int ID_BITS      = 22;
    localparam int SLOT_W       = 4;
    localparam int CNT_W        = 5;
    localparam int POOL_SIZE    = 24;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 2 * (ENTRIES + 3);
    localparam int HOLD_CYCLES  = 300;
    localparam logic [1:0] CMD_RESERVED = 2'd3;
    localparam logic [ID_BITS-1:0] MAX_ID = {ID_BITS{1'b1}};

    typedef struct packed {
        logic [1:0]         cmd;
        logic               bulk;
        logic [ID_BITS-1:0] proc_id;
        logic               is_leader;
        logic [15:0]        run_state;
        logic [5:0]         term_state;
    } t_trace_req;

    typedef struct packed {
        t_status            status;
        logic               recorded;
        logic [SLOT_W-1:0]  slot;
        logic [ID_BITS-1:0] rec_proc_id;
        logic [15:0]        rec_state;
        logic [CNT_W-1:0]   live_count;
        logic               mode_all;
        logic [CNT_W-1:0]   fill_level;
    } t_trace_res;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_valid      = 1'b0;
    logic [1:0]         i_cmd        = '0;
    logic               i_bulk       = 1'b0;
    logic [ID_BITS-1:0] i_proc_id    = '0;
    logic               i_is_leader  = 1'b0;
    logic [15:0]        i_run_state  = '0;
    logic [5:0]         i_term_state = '0;
    logic               i_ready      = 1'b0;
    logic               o_ready;
    logic               o_valid;
    logic [1:0]         o_status;
    logic               o_recorded;
    logic [SLOT_W-1:0]  o_slot;
    logic [ID_BITS-1:0] o_rec_proc_id;
    logic [15:0]        o_rec_state;
    logic [CNT_W-1:0]   o_live_count;
    logic               o_mode_all;
    logic [CNT_W-1:0]   o_fill_level;

    process_trace_filter_top #(
        .ENTRIES(ENTRIES),
        .ID_BITS(ID_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_cmd        (i_cmd),
        .i_bulk       (i_bulk),
        .i_proc_id    (i_proc_id),
        .i_is_leader  (i_is_leader),
        .i_run_state  (i_run_state),
        .i_term_state (i_term_state),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_recorded   (o_recorded),
        .o_slot       (o_slot),
        .o_rec_proc_id(o_rec_proc_id),
        .o_rec_state  (o_rec_state),
        .o_live_count (o_live_count),
        .o_mode_all   (o_mode_all),
        .o_fill_level (o_fill_level)
    );

    always #5 i_clk = ~i_clk;

    // Model of the filter state
    logic [ID_BITS-1:0] exc_ids [ENTRIES];
    logic               exc_deleted [ENTRIES];
    int                 live_n;
    int                 ring_n;
    logic               trace_all_m;
    logic               started_m;
    logic [SLOT_W-1:0]  ring_wr;

    t_trace_req request_q [$];
    t_trace_res outcome_q [$];
    t_trace_req cur_req;

    logic [ID_BITS-1:0] id_pool [POOL_SIZE];
    logic               gen_mode   = 1'b0;
    int                 epoch_left = 0;
    int                 send_idle_pct  = 0;
    int                 recv_stall_pct = 0;
    logic               hold_start = 1'b0;
    int                 hold_cnt   = 0;
    int                 mismatch_cnt = 0;
    int                 result_idx   = 0;

    function automatic void clear_exceptions();
        for (int i = 0; i < ENTRIES; i++) begin
            exc_ids[i]     = '0;
            exc_deleted[i] = 1'b0;
        end
        live_n = 0;
    endfunction

    // First slot holding the id decides; a deleted mark means not found
    function automatic int lookup_live(logic [ID_BITS-1:0] id);
        if (id == '0)
            return -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (exc_ids[i] == id)
                return exc_deleted[i] ? -1 : i;
        end
        return -1;
    endfunction

    function automatic t_trace_res filter_step(t_trace_req rq);
        t_trace_res  res;
        int          hit;
        int          free_slot;
        logic        enable;
        logic        ok;
        logic [15:0] st;
        res        = '0;
        res.status = ST_DONE;
        enable     = (rq.cmd == CMD_ENABLE);
        if (rq.cmd == CMD_ENABLE || rq.cmd == CMD_DISABLE) begin
            started_m = 1'b1;
            if (rq.bulk) begin
                clear_exceptions();
                trace_all_m = enable;
            end else if (rq.proc_id != '0) begin
                hit = lookup_live(rq.proc_id);
                if (trace_all_m != enable) begin
                    if (hit < 0) begin
                        free_slot = -1;
                        for (int i = ENTRIES - 1; i >= 0; i--) begin
                            if (exc_deleted[i] || exc_ids[i] == '0)
                                free_slot = i;
                        end
                        if (free_slot < 0) begin
                            res.status = ST_FULL;
                        end else begin
                            exc_ids[free_slot]     = rq.proc_id;
                            exc_deleted[free_slot] = 1'b0;
                            if (live_n < ENTRIES)
                                live_n++;
                        end
                    end
                end else if (hit >= 0) begin
                    exc_deleted[hit] = 1'b1;
                    if (live_n > 0)
                        live_n--;
                end
            end
        end else if (rq.cmd == CMD_EVENT) begin
            res.status = ST_SKIP;
            if (started_m && rq.is_leader &&
                    (trace_all_m != (lookup_live(rq.proc_id) >= 0))) begin
                if (rq.term_state == TERM_ZOMBIE || rq.term_state == TERM_DEAD) begin
                    st = 16'(rq.term_state);
                    ok = 1'b1;
                end else begin
                    st = rq.run_state;
                    ok = rq.run_state inside {RUN_RUNNING, RUN_INTERRUPT, RUN_UNINTR,
                                              RUN_STOPPED, RUN_STOP_WKILL};
                end
                if (ok) begin
                    res.status      = ST_DONE;
                    res.recorded    = 1'b1;
                    res.slot        = ring_wr;
                    res.rec_proc_id = rq.proc_id;
                    res.rec_state   = st;
                    ring_wr         = ring_wr + 1'b1;
                    if (ring_n < ENTRIES)
                        ring_n++;
                end
            end
        end
        res.live_count = CNT_W'(live_n);
        res.mode_all   = trace_all_m;
        res.fill_level = CNT_W'(ring_n);
        return res;
    endfunction

    function automatic void check_field(string name, longint unsigned got,
                                        longint unsigned want);
        if (got != want) begin
            if (mismatch_cnt < MAX_REPORTS)
                $display("result %0d: %s expected %0h, got %0h", result_idx, name, want, got);
            mismatch_cnt++;
        end
    endfunction

    task automatic push_req(logic [1:0] cmd, logic bulk, logic [ID_BITS-1:0] id,
                            logic leader, logic [15:0] rs, logic [5:0] ts);
        request_q.push_back('{cmd: cmd, bulk: bulk, proc_id: id, is_leader: leader,
                              run_state: rs, term_state: ts});
    endtask

    // Epochs open with a bulk command; inside one, most requests add or
    // remove pool ids against the known mode, or raise events on them.
    task automatic add_random(int count);
        t_trace_req rq;
        int         pick;
        repeat (count) begin
            rq.cmd        = CMD_EVENT;
            rq.bulk       = 1'b0;
            rq.proc_id    = id_pool[$urandom_range(POOL_SIZE - 1)];
            rq.is_leader  = 1'($urandom_range(1));
            rq.run_state  = 16'($urandom);
            rq.term_state = 6'($urandom);
            if (epoch_left == 0) begin
                gen_mode   = 1'($urandom_range(1));
                epoch_left = $urandom_range(20, 80);
                rq.cmd     = gen_mode ? CMD_ENABLE : CMD_DISABLE;
                rq.bulk    = 1'b1;
            end else begin
                epoch_left--;
                pick = $urandom_range(99);
                if (pick < 38) begin
                    rq.cmd = gen_mode ? CMD_DISABLE : CMD_ENABLE;
                end else if (pick < 52) begin
                    rq.cmd = gen_mode ? CMD_ENABLE : CMD_DISABLE;
                end else if (pick < 90) begin
                    rq.bulk      = 1'($urandom_range(1));
                    rq.is_leader = ($urandom_range(99) < 88);
                    if ($urandom_range(99) < 20)
                        rq.proc_id = ID_BITS'($urandom);
                    case ($urandom_range(9))
                        0: rq.run_state = RUN_RUNNING;
                        1: rq.run_state = RUN_INTERRUPT;
                        2: rq.run_state = RUN_UNINTR;
                        3: rq.run_state = RUN_STOPPED;
                        4: rq.run_state = RUN_STOP_WKILL;
                        5, 6: rq.term_state = $urandom_range(1) ? TERM_ZOMBIE : TERM_DEAD;
                        default: ;
                    endcase
                end else if (pick < 93) begin
                    rq.cmd  = CMD_RESERVED;
                    rq.bulk = 1'($urandom_range(1));
                end else if (pick < 96) begin
                    rq.cmd     = $urandom_range(1) ? CMD_ENABLE : CMD_DISABLE;
                    rq.proc_id = '0;
                end else begin
                    rq.cmd     = $urandom_range(1) ? CMD_ENABLE : CMD_DISABLE;
                    rq.proc_id = ID_BITS'($urandom);
                end
            end
            request_q.push_back(rq);
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (request_q.size() != 0 || i_valid || outcome_q.size() != 0 || hold_cnt != 0);
    endtask

    always @(posedge i_clk) begin : request_driver
        t_trace_req nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            clear_exceptions();
            trace_all_m = 1'b0;
            started_m   = 1'b0;
            ring_wr     = '0;
            ring_n      = 0;
        end else begin
            if (i_valid && o_ready)
                outcome_q.push_back(filter_step(cur_req));
            if (!i_valid || o_ready) begin
                if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = request_q.pop_front();
                    cur_req = nxt;
                    i_valid      <= 1'b1;
                    i_cmd        <= nxt.cmd;
                    i_bulk       <= nxt.bulk;
                    i_proc_id    <= nxt.proc_id;
                    i_is_leader  <= nxt.is_leader;
                    i_run_state  <= nxt.run_state;
                    i_term_state <= nxt.term_state;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_ready
        if (!i_rst_n) begin
            i_ready  <= 1'b0;
            hold_cnt <= 0;
        end else if (hold_start) begin
            hold_cnt <= HOLD_CYCLES;
            i_ready  <= 1'b0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            i_ready  <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_trace_res want;
        if (i_rst_n && o_valid && i_ready) begin
            if (outcome_q.size() == 0) begin
                if (mismatch_cnt < MAX_REPORTS)
                    $display("result %0d arrived with no request outstanding", result_idx);
                mismatch_cnt++;
            end else begin
                want = outcome_q.pop_front();
                check_field("status", o_status, want.status);
                check_field("recorded", o_recorded, want.recorded);
                check_field("slot", o_slot, want.slot);
                check_field("rec_proc_id", o_rec_proc_id, want.rec_proc_id);
                check_field("rec_state", o_rec_state, want.rec_state);
                check_field("live_count", o_live_count, want.live_count);
                check_field("mode_all", o_mode_all, want.mode_all);
                check_field("fill_level", o_fill_level, want.fill_level);
            end
            result_idx++;
        end
    end

    initial begin : stimulus
        id_pool[0] = ID_BITS'(1);
        id_pool[1] = MAX_ID;
        for (int i = 2; i < POOL_SIZE; i++)
            id_pool[i] = ID_BITS'($urandom_range(2, (1 << ID_BITS) - 2));
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Opening: not started yet, reserved command, id zero, then fill the table
        push_req(CMD_EVENT, 1'b0, MAX_ID, 1'b1, RUN_RUNNING, 6'd0);
        push_req(CMD_RESERVED, 1'b1, MAX_ID, 1'b1, RUN_RUNNING, 6'd0);
        push_req(CMD_ENABLE, 1'b0, '0, 1'b0, 16'hFFFF, 6'h3F);
        push_req(CMD_EVENT, 1'b0, MAX_ID, 1'b1, RUN_STOP_WKILL, 6'd0);
        for (int k = 1; k <= ENTRIES; k++)
            push_req(CMD_ENABLE, 1'b0, (k == ENTRIES) ? MAX_ID : ID_BITS'(k), 1'b0, 16'd0, 6'd0);
        push_req(CMD_ENABLE, 1'b0, ID_BITS'(ENTRIES + 1), 1'b0, 16'd0, 6'd0);
        push_req(CMD_EVENT, 1'b0, MAX_ID, 1'b1, RUN_STOP_WKILL, 6'd0);
        push_req(CMD_EVENT, 1'b0, MAX_ID, 1'b0, RUN_RUNNING, 6'd0);
        push_req(CMD_DISABLE, 1'b0, MAX_ID, 1'b0, 16'd0, 6'd0);
        push_req(CMD_EVENT, 1'b0, 22'd5, 1'b1, 16'hFFFF, TERM_ZOMBIE);
        push_req(CMD_EVENT, 1'b0, 22'd5, 1'b1, 16'hFFFF, TERM_DEAD);
        push_req(CMD_EVENT, 1'b0, 22'd5, 1'b1, 16'hFFFF, 6'h3F);
        push_req(CMD_ENABLE, 1'b1, '0, 1'b0, 16'd0, 6'd0);
        push_req(CMD_EVENT, 1'b0, '0, 1'b1, RUN_STOPPED, 6'd0);
        wait_idle();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        add_random(300);
        wait_idle();

        send_idle_pct = 87;
        add_random(250);
        wait_idle();

        send_idle_pct  = 0;
        recv_stall_pct = 87;
        add_random(250);
        wait_idle();

        send_idle_pct  = 20;
        recv_stall_pct = 20;
        add_random(250);
        wait_idle();

        // Back the block up: keep offering requests while results are held off
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        add_random(60);
        @(negedge i_clk);
        hold_start = 1'b1;
        @(negedge i_clk);
        hold_start = 1'b0;
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0 && outcome_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin : watchdog
        #5000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
